FILE: hdl/sdrdfr_pkg.sv
// Package for the receive datagram I/Q deframer.
// Holds packet geometry, header bytes, status and kind codes, and the result record.
// No dependencies.
package sdrdfr_pkg;

  localparam int unsigned PKT_LEN    = 1032;
  localparam int unsigned POS_W      = 11;
  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 88;

  localparam logic [POS_W-1:0] POS_HDR_END   = POS_W'(4);
  localparam logic [POS_W-1:0] POS_SEQ_END   = POS_W'(8);
  localparam logic [POS_W-1:0] POS_PKT_LEN   = POS_W'(PKT_LEN);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(PKT_LEN - 1);
  localparam logic [POS_W-1:0] POS_FRAME0    = POS_W'(8);

  localparam logic [7:0] SYNC_BYTE = 8'h7f;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LEN  = 2'd1,
    ST_HDR  = 2'd2,
    ST_SYNC = 2'd3
  } status_t;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [SAMPLE_W-1:0]  i_sample;
    logic [SAMPLE_W-1:0]  q_sample;
    logic [SEQ_W-1:0]     seq;
    status_t              status;
  } res_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'hef;
      2'd1:    b = 8'hfe;
      2'd2:    b = 8'h01;
      2'd3:    b = 8'h06;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

FILE: hdl/sdr_rx_packet_iq_deframer_top.sv
// Top level of the receive datagram I/Q deframer.
// Depends on sdrdfr_pkg, sdrdfr_in_stage, sdrdfr_parse and sdrdfr_out_stage.
//
// Takes a 1032-byte receive datagram one byte per transaction (tlast on the final byte),
// checks the ef fe 01 06 header and the three 7f sync bytes of each 512-byte frame, and
// emits one I/Q transaction per 8-byte slot (tuser 0) plus one status transaction on the
// last byte (tuser 1: 0 ok, 1 wrong length, 2 bad header, 3 bad sync). Samples leave before
// the datagram is validated: drop them when the status is not ok. One byte is taken per
// clock unless the result register is full and stalled; each result passes through an input
// register, the parser and the result register.
module sdr_rx_packet_iq_deframer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [23:0] i_sample, [47:24] q_sample,
                                  // [79:48] sequence_number, [81:80] packet_status
  output logic        out_tuser   // result_kind
);

  logic             hold_valid;
  logic [7:0]       hold_data;
  logic             hold_last;
  logic             hold_take;
  logic             res_free;
  logic             res_valid;
  sdrdfr_pkg::res_t res;

  sdrdfr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_data    (in_tdata),
    .in_last    (in_tlast),
    .hold_valid (hold_valid),
    .hold_data  (hold_data),
    .hold_last  (hold_last),
    .hold_take  (hold_take)
  );

  sdrdfr_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (hold_valid),
    .byte_data  (hold_data),
    .byte_last  (hold_last),
    .res_free   (res_free),
    .byte_take  (hold_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  sdrdfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_valid && hold_take),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_kind  (out_tuser)
  );

endmodule

FILE: hdl/sdrdfr_in_stage.sv
// Input register for the deframer byte stream.
// Depends on sdrdfr_pkg.
module sdrdfr_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [sdrdfr_pkg::IN_DATA_W-1:0] in_data,
  input  logic                            in_last,
  output logic                            hold_valid,
  output logic [sdrdfr_pkg::IN_DATA_W-1:0] hold_data,
  output logic                            hold_last,
  input  logic                            hold_take
);

  logic                             valid_r, valid_nxt;
  logic [sdrdfr_pkg::IN_DATA_W-1:0] data_r;
  logic                             last_r;

  assign in_ready = !valid_r || hold_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data;
      last_r <= in_last;
    end
  end

  assign hold_valid = valid_r;
  assign hold_data  = data_r;
  assign hold_last  = last_r;

endmodule

FILE: hdl/sdrdfr_parse.sv
// Datagram parser: position tracking, header and sync checks, I/Q assembly.
// Depends on sdrdfr_pkg.
module sdrdfr_parse (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             byte_valid,
  input  logic [sdrdfr_pkg::IN_DATA_W-1:0] byte_data,
  input  logic                             byte_last,
  input  logic                             res_free,
  output logic                             byte_take,
  output logic                             res_valid,
  output sdrdfr_pkg::res_t                 res
);

  logic [sdrdfr_pkg::POS_W-1:0]    pos_r, pos_nxt;
  sdrdfr_pkg::status_t             fault_r, fault_nxt;
  logic [sdrdfr_pkg::SAMPLE_W-1:0] held_i_r, held_i_nxt;
  logic [15:0]                     partial_r, partial_nxt;
  logic [sdrdfr_pkg::SEQ_W-1:0]    seq_r, seq_nxt;

  logic [sdrdfr_pkg::POS_W-1:0]    rel_full;
  logic [8:0]                      rel;
  logic                            in_frames;
  logic                            sample_hit;
  logic [sdrdfr_pkg::SAMPLE_W-1:0] word;

  assign rel_full  = pos_r - sdrdfr_pkg::POS_FRAME0;
  assign rel       = rel_full[8:0];
  assign in_frames = (pos_r >= sdrdfr_pkg::POS_SEQ_END) && (pos_r < sdrdfr_pkg::POS_PKT_LEN);
  assign word      = {partial_r, byte_data};
  assign sample_hit = in_frames && (rel >= 9'd8) && (rel[2:0] == 3'd5);

  assign res_valid = byte_valid && (byte_last || sample_hit);
  assign byte_take = byte_valid && (res_free || !(byte_last || sample_hit));

  always_comb begin
    pos_nxt     = pos_r;
    fault_nxt   = fault_r;
    held_i_nxt  = held_i_r;
    partial_nxt = partial_r;
    seq_nxt     = seq_r;
    if (pos_r < sdrdfr_pkg::POS_HDR_END) begin
      if (byte_data != sdrdfr_pkg::hdr_byte(pos_r[1:0]) && fault_r == sdrdfr_pkg::ST_OK) begin
        fault_nxt = sdrdfr_pkg::ST_HDR;
      end
    end else if (pos_r < sdrdfr_pkg::POS_SEQ_END) begin
      seq_nxt = {seq_r[sdrdfr_pkg::SEQ_W-9:0], byte_data};
    end else if (in_frames) begin
      if (rel < 9'd3) begin
        if (byte_data != sdrdfr_pkg::SYNC_BYTE && fault_r == sdrdfr_pkg::ST_OK) begin
          fault_nxt = sdrdfr_pkg::ST_SYNC;
        end
      end else if (rel >= 9'd8) begin
        case (rel[2:0])
          3'd0, 3'd1, 3'd3, 3'd4: partial_nxt = {partial_r[7:0], byte_data};
          3'd2:                   held_i_nxt  = word;
          default:                ;
        endcase
      end
    end
    if (pos_r < sdrdfr_pkg::POS_PKT_LEN) begin
      pos_nxt = pos_r + sdrdfr_pkg::POS_W'(1);
    end
  end

  always_comb begin
    res          = '0;
    res.seq      = seq_nxt;
    if (byte_last) begin
      res.kind   = sdrdfr_pkg::KIND_STATUS;
      res.status = (pos_r != sdrdfr_pkg::POS_LAST) ? sdrdfr_pkg::ST_LEN : fault_r;
    end else begin
      res.kind     = sdrdfr_pkg::KIND_SAMPLE;
      res.i_sample = held_i_r;
      res.q_sample = word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      fault_r   <= sdrdfr_pkg::ST_OK;
      held_i_r  <= '0;
      partial_r <= '0;
      seq_r     <= '0;
    end else if (byte_take) begin
      if (byte_last) begin
        pos_r     <= '0;
        fault_r   <= sdrdfr_pkg::ST_OK;
        held_i_r  <= '0;
        partial_r <= '0;
        seq_r     <= '0;
      end else begin
        pos_r     <= pos_nxt;
        fault_r   <= fault_nxt;
        held_i_r  <= held_i_nxt;
        partial_r <= partial_nxt;
        seq_r     <= seq_nxt;
      end
    end
  end

endmodule

FILE: hdl/sdrdfr_out_stage.sv
// Result register and packing onto the output stream.
// Depends on sdrdfr_pkg.
module sdrdfr_out_stage (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              res_load,
  input  sdrdfr_pkg::res_t                  res,
  output logic                              res_free,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sdrdfr_pkg::OUT_DATA_W-1:0] out_data,
  output logic                              out_kind
);

  logic             valid_r, valid_nxt;
  sdrdfr_pkg::res_t res_r;

  assign res_free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (res_free) begin
      valid_nxt = res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = res_r.kind;
  assign out_data  = {6'd0, res_r.status, res_r.seq, res_r.q_sample, res_r.i_sample};

endmodule

FILE: sim/sdr_rx_packet_iq_deframer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for sdr_rx_packet_iq_deframer_top: streams receive datagrams,
// predicts every I/Q and status transaction in step with the input, compares on arrival.
// Depends on sdrdfr_pkg and the deframer RTL.
module sdr_rx_packet_iq_deframer_top_tb;

  localparam logic [31:0] HDR_WORD   = 32'hef_fe_01_06;
  localparam int unsigned FRAME_LEN  = 512;
  localparam int unsigned SLOT_FIRST = 8;
  localparam int unsigned SLOT_END   = SLOT_FIRST + 63 * 8;
  localparam int unsigned LONG_HOLD  = 400;

  typedef enum int {
    DG_OK, DG_BAD_HDR, DG_BAD_SYNC, DG_HDR_AND_SYNC,
    DG_LONG, DG_CUT_ON_SAMPLE, DG_CUT_RANDOM, DG_TWO_SYNC
  } dgram_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;
  logic        out_tuser;

  byte_item_t        pending_bytes[$];
  sdrdfr_pkg::res_t  expected_results[$];
  logic [7:0]        dgram [sdrdfr_pkg::PKT_LEN];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned mismatch_count = 0;

  // deframer state as seen by the predictor
  logic [10:0]         byte_pos = '0;
  sdrdfr_pkg::status_t first_fault = sdrdfr_pkg::ST_OK;
  logic [23:0]         held_i = '0;
  logic [15:0]         partial = '0;
  logic [31:0]         seq_val = '0;

  sdr_rx_packet_iq_deframer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic deframe_byte(input logic [7:0] b, input logic last);
    int unsigned      p;
    int unsigned      rel;
    logic [23:0]      q_val;
    logic             got_pair;
    sdrdfr_pkg::res_t r;
    p = byte_pos;
    q_val = '0;
    got_pair = 1'b0;
    if (p < 4) begin
      if (b != HDR_WORD[31 - 8 * p -: 8] && first_fault == sdrdfr_pkg::ST_OK)
        first_fault = sdrdfr_pkg::ST_HDR;
    end else if (p < 8) begin
      seq_val = {seq_val[23:0], b};
    end else if (p < sdrdfr_pkg::PKT_LEN) begin
      rel = (p - sdrdfr_pkg::POS_FRAME0) % FRAME_LEN;
      if (rel < 3) begin
        if (b != sdrdfr_pkg::SYNC_BYTE && first_fault == sdrdfr_pkg::ST_OK)
          first_fault = sdrdfr_pkg::ST_SYNC;
      end else if (rel >= SLOT_FIRST && rel < SLOT_END) begin
        case ((rel - SLOT_FIRST) % 8)
          0, 1, 3, 4: partial = {partial[7:0], b};
          2:          held_i = {partial, b};
          5: begin
            q_val = {partial, b};
            got_pair = 1'b1;
          end
          default: ;
        endcase
      end
    end
    if (p < sdrdfr_pkg::PKT_LEN) byte_pos = byte_pos + 1'b1;
    if (last) begin
      r.kind = sdrdfr_pkg::KIND_STATUS;
      r.i_sample = '0;
      r.q_sample = '0;
      r.seq = seq_val;
      r.status = (p != sdrdfr_pkg::PKT_LEN - 1) ? sdrdfr_pkg::ST_LEN : first_fault;
      expected_results.push_back(r);
      byte_pos = '0;
      first_fault = sdrdfr_pkg::ST_OK;
      held_i = '0;
      partial = '0;
      seq_val = '0;
    end else if (got_pair) begin
      r.kind = sdrdfr_pkg::KIND_SAMPLE;
      r.i_sample = held_i;
      r.q_sample = q_val;
      r.seq = seq_val;
      r.status = sdrdfr_pkg::ST_OK;
      expected_results.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : byte_driver
    byte_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) deframe_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.data;
          in_tlast <= nxt.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    sdrdfr_pkg::res_t want;
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      holds_served <= holds_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: no transaction expected, got tuser %0b tdata %h",
                 $time, out_tuser, out_tdata);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", want.kind, out_tuser);
        check_field("i_sample", want.i_sample, out_tdata[23:0]);
        check_field("q_sample", want.q_sample, out_tdata[47:24]);
        check_field("sequence_number", want.seq, out_tdata[79:48]);
        check_field("packet_status", want.status, out_tdata[81:80]);
        check_field("tdata padding", '0, out_tdata[87:82]);
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'h80;
      3:       return 8'h7f;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic build_datagram();
    for (int i = 0; i < sdrdfr_pkg::PKT_LEN; i++) dgram[i] = rand_byte();
    for (int i = 0; i < 4; i++) dgram[i] = HDR_WORD[31 - 8 * i -: 8];
    for (int f = 0; f < 2; f++)
      for (int k = 0; k < 3; k++)
        dgram[sdrdfr_pkg::POS_FRAME0 + FRAME_LEN * f + k] = sdrdfr_pkg::SYNC_BYTE;
  endtask

  task automatic push_bytes(input int unsigned count);
    byte_item_t it;
    for (int unsigned i = 0; i < count; i++) begin
      it.data = (i < sdrdfr_pkg::PKT_LEN) ? dgram[i] : rand_byte();
      it.last = (i == count - 1);
      pending_bytes.push_back(it);
    end
  endtask

  task automatic spoil(input int unsigned idx);
    dgram[idx] = dgram[idx] ^ (8'h01 << $urandom_range(7));
  endtask

  function automatic int unsigned sync_pos();
    return sdrdfr_pkg::POS_FRAME0 + FRAME_LEN * $urandom_range(1) + $urandom_range(2);
  endfunction

  task automatic queue_datagram(input dgram_mode_t mode);
    int unsigned count;
    build_datagram();
    count = sdrdfr_pkg::PKT_LEN;
    case (mode)
      DG_BAD_HDR:      spoil($urandom_range(3));
      DG_BAD_SYNC:     spoil(sync_pos());
      DG_HDR_AND_SYNC: begin
        spoil($urandom_range(3));
        spoil($urandom_range(3));
        spoil(sync_pos());
      end
      DG_TWO_SYNC: begin
        spoil(sdrdfr_pkg::POS_FRAME0 + $urandom_range(2));
        spoil(sdrdfr_pkg::POS_FRAME0 + FRAME_LEN + $urandom_range(2));
      end
      DG_LONG:          count = sdrdfr_pkg::PKT_LEN + $urandom_range(1, 40);
      DG_CUT_ON_SAMPLE: count = sdrdfr_pkg::POS_FRAME0 + SLOT_FIRST
                                + 8 * $urandom_range(7) + 6;
      DG_CUT_RANDOM:    count = $urandom_range(1, 96);
      default: ;
    endcase
    push_bytes(count);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || expected_results.size() != 0);
  endtask

  initial begin
    int unsigned idle_plan [4][2];
    idle_plan = '{'{0, 0}, '{76, 0}, '{0, 76}, '{15, 15}};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // lone flagged byte, then short datagrams carrying extreme sequence bytes and faults
    build_datagram();
    dgram[0] = 8'h00;
    push_bytes(1);
    build_datagram();
    for (int i = 4; i < 8; i++) dgram[i] = 8'hff;
    push_bytes(8);
    build_datagram();
    dgram[0] = 8'h00;
    dgram[4] = 8'h80;
    push_bytes(5);
    build_datagram();
    for (int i = 4; i < 8; i++) dgram[i] = 8'h00;
    dgram[7] = 8'h01;
    dgram[sdrdfr_pkg::POS_FRAME0] = 8'hff;
    push_bytes(9);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph][0];
      stall_pct = idle_plan[ph][1];
      if (ph == 0) begin
        queue_datagram(DG_OK);
        // hold the result side off while the input keeps streaming
        hold_requests++;
      end
      queue_datagram(DG_CUT_ON_SAMPLE);
      build_datagram();
      push_bytes($urandom_range(1, 12));
      queue_datagram(DG_CUT_RANDOM);
      wait_drained();
    end

    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
